[rtl/skt_pkg.sv]
`default_nettype none

package skt_pkg;

    // command codes
    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_INSERT  = 3'd1;
    localparam logic [2:0] CMD_DELETE  = 3'd2;
    localparam logic [2:0] CMD_LOOKUP  = 3'd3;
    localparam logic [2:0] CMD_REPLACE = 3'd4;
    localparam logic [2:0] CMD_READ    = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_DUP       = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_RANGE     = 3'd5;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] key;
        logic [31:0] payload;
        logic [5:0]  position;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] key_out;
        logic [31:0] payload_out;
        logic [6:0]  count;
    } t_out_beat;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic cap;  // capture compare flags against the incoming key
        logic ins;  // open a slot and insert
        logic del;  // close the gap at the matching slot
        logic rep;  // overwrite payload at the matching slot
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/skt_stream_if.sv]
`default_nettype none

interface skt_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     beat;

    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

`default_nettype wire

[rtl/sorted_key_table.sv]
// Sorted key table: holds up to DEPTH (key, payload) records in ascending
// unsigned key order with unique keys. Each input beat carries one command
// (clear, insert, delete, lookup, replace, read at position) and yields
// exactly one output beat with a status, the found or read record (zero
// otherwise) and the record count after the command. In the accept cycle
// every cell compares its key with the incoming key and latches
// less-than / equal flags; then, in the execute state, an insert or delete
// shifts the row by one place toward or away from the insert or delete
// point, and the result is loaded into the output register. A new beat is
// accepted while the previous result still waits in the output register;
// the execute cycle waits only if that register is still occupied. There
// is no clearing pass after reset: the count alone decides which cells
// hold live records. Only the low KEY_BITS of key and DATA_BITS of payload
// are stored; reads at or past the count report out of range.
`default_nettype none

module sorted_key_table #(
    parameter int DEPTH     = 64,
    parameter int KEY_BITS  = 32,
    parameter int DATA_BITS = 32
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    skt_stream_if.sink      i_in,
    skt_stream_if.source    o_out
);
    import skt_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (CNT_W > 7) ? CNT_W : 7;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                 r_state;
    logic [CNT_W-1:0]     r_count, n_count;

    // latched command beat
    logic [2:0]           r_cmd;
    logic [KEY_BITS-1:0]  r_key;
    logic [DATA_BITS-1:0] r_pay;
    logic [DEPTH-1:0]     r_rd_sel;

    // output register
    logic                 r_out_valid;
    t_out_beat            r_out_beat, n_out_beat;

    // cell row
    t_cell_ctl            w_ctl;
    logic [KEY_BITS-1:0]  w_key [DEPTH];
    logic [DATA_BITS-1:0] w_pay [DEPTH];
    logic [DEPTH-1:0]     w_lt, w_eq, w_valid, w_hit;

    logic                 w_accept, w_fire, w_found, w_rd_ok;
    logic                 w_ins, w_del, w_rep;
    logic [KEY_BITS-1:0]  w_sel_key;
    logic [DATA_BITS-1:0] w_sel_pay;
    logic [EXT_W-1:0]     w_count_ext;

    // no beat is taken while reset is held
    assign i_in.ready = i_rst_n && (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    // execute once the output slot is free or being emptied this cycle
    assign w_fire     = (r_state == S_EXEC) && (!r_out_valid || o_out.ready);

    // ---------------------------------------------------------------
    // chain of cells, each neighbor wired to the next
    // ---------------------------------------------------------------
    assign w_ctl.cap = w_accept;
    assign w_ctl.ins = w_ins;
    assign w_ctl.del = w_del;
    assign w_ctl.rep = w_rep;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KEY_BITS-1:0]  w_prev_key, w_next_key;
        logic [DATA_BITS-1:0] w_prev_pay, w_next_pay;
        logic                 w_prev_lt;

        // a cell is live when it sits below the record count
        assign w_valid[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_prev_key = r_key;
            assign w_prev_pay = r_pay;
            assign w_prev_lt  = 1'b1;
        end else begin : g_body
            assign w_prev_key = w_key[g-1];
            assign w_prev_pay = w_pay[g-1];
            assign w_prev_lt  = w_lt[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next_key = w_key[g];
            assign w_next_pay = w_pay[g];
        end else begin : g_mid
            assign w_next_key = w_key[g+1];
            assign w_next_pay = w_pay[g+1];
        end

        skt_cell #(
            .KEY_BITS  (KEY_BITS),
            .DATA_BITS (DATA_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_valid    (w_valid[g]),
            .i_cmp_key  (i_in.beat.key[KEY_BITS-1:0]),
            .i_bc_key   (r_key),
            .i_bc_pay   (r_pay),
            .i_prev_key (w_prev_key),
            .i_prev_pay (w_prev_pay),
            .i_prev_lt  (w_prev_lt),
            .i_next_key (w_next_key),
            .i_next_pay (w_next_pay),
            .o_key      (w_key[g]),
            .o_pay      (w_pay[g]),
            .o_lt       (w_lt[g]),
            .o_eq       (w_eq[g])
        );
    end

    // ---------------------------------------------------------------
    // command latch and state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_in.beat.cmd;
            r_key <= i_in.beat.key[KEY_BITS-1:0];
            r_pay <= i_in.beat.payload[DATA_BITS-1:0];
            for (int i = 0; i < DEPTH; i++) begin
                // read select: matching position, and only among live records
                r_rd_sel[i] <= (32'(i) == 32'(i_in.beat.position)) && w_valid[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_beat <= n_out_beat;
        end
    end

    // ---------------------------------------------------------------
    // execute: decode the flags from the cell row
    // ---------------------------------------------------------------
    assign w_found = |w_eq;
    assign w_rd_ok = |r_rd_sel;
    assign w_hit   = (r_cmd == CMD_READ) ? r_rd_sel : w_eq;

    // and-or select of the single hit cell
    always_comb begin
        w_sel_key = '0;
        w_sel_pay = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel_key = w_sel_key | ({KEY_BITS{w_hit[i]}} & w_key[i]);
            w_sel_pay = w_sel_pay | ({DATA_BITS{w_hit[i]}} & w_pay[i]);
        end
    end

    always_comb begin
        logic [2:0]  v_status;
        logic        v_data;
        v_status = ST_OK;
        v_data   = 1'b0;
        n_count  = r_count;
        w_ins    = 1'b0;
        w_del    = 1'b0;
        w_rep    = 1'b0;
        unique case (r_cmd)
            CMD_CLEAR: begin
                n_count = '0;
            end
            CMD_INSERT: begin
                if (r_count == CNT_W'(DEPTH)) begin
                    v_status = ST_FULL;
                end else if (w_found) begin
                    v_status = ST_DUP;
                end else begin
                    w_ins   = w_fire;
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_DELETE: begin
                if (r_count == '0) begin
                    v_status = ST_EMPTY;
                end else if (!w_found) begin
                    v_status = ST_NOT_FOUND;
                end else begin
                    w_del   = w_fire;
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_LOOKUP: begin
                if (w_found) begin
                    v_data = 1'b1;
                end else begin
                    v_status = ST_NOT_FOUND;
                end
            end
            CMD_REPLACE: begin
                if (w_found) begin
                    w_rep = w_fire;
                end else begin
                    v_status = ST_NOT_FOUND;
                end
            end
            CMD_READ: begin
                if (w_rd_ok) begin
                    v_data = 1'b1;
                end else begin
                    v_status = ST_RANGE;
                end
            end
            default: begin
                // unused command codes
                v_status = ST_RANGE;
            end
        endcase
        n_out_beat.status      = v_status;
        n_out_beat.key_out     = v_data ? 32'(w_sel_key) : 32'd0;
        n_out_beat.payload_out = v_data ? 32'(w_sel_pay) : 32'd0;
        n_out_beat.count       = 7'(EXT_W'(n_count));
    end

    assign w_count_ext = EXT_W'(r_count);
    assign o_out.valid = r_out_valid;
    assign o_out.beat  = r_out_beat;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // record count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count_ext <= EXT_W'(DEPTH))
        else $error("record count above depth");

    // keys are unique, so at most one live cell matches
    a_eq_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> $onehot0(w_eq))
        else $error("more than one cell matches the key");

    // sorted order: less-than flags form a prefix of the row
    a_lt_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (((w_lt + DEPTH'(1)) & w_lt) == '0))
        else $error("less-than flags not a prefix, order broken");

    // an accepted beat puts the control in the execute state in the following cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted beat not executed");

endmodule

`default_nettype wire

[rtl/skt_cell.sv]
`default_nettype none

module skt_cell #(
    parameter int KEY_BITS  = 32,
    parameter int DATA_BITS = 32
) (
    input  wire                     i_clk,
    input  skt_pkg::t_cell_ctl      i_ctl,
    input  wire                     i_valid,
    input  wire  [KEY_BITS-1:0]     i_cmp_key,
    input  wire  [KEY_BITS-1:0]     i_bc_key,
    input  wire  [DATA_BITS-1:0]    i_bc_pay,
    input  wire  [KEY_BITS-1:0]     i_prev_key,
    input  wire  [DATA_BITS-1:0]    i_prev_pay,
    input  wire                     i_prev_lt,
    input  wire  [KEY_BITS-1:0]     i_next_key,
    input  wire  [DATA_BITS-1:0]    i_next_pay,
    output logic [KEY_BITS-1:0]     o_key,
    output logic [DATA_BITS-1:0]    o_pay,
    output logic                    o_lt,
    output logic                    o_eq
);
    import skt_pkg::*;

    logic [KEY_BITS-1:0]  r_key, n_key;
    logic [DATA_BITS-1:0] r_pay, n_pay;
    logic                 r_lt, r_eq;

    always_comb begin
        n_key = r_key;
        n_pay = r_pay;
        if (i_ctl.ins && !r_lt) begin
            // first cell past the smaller keys takes the new record, the rest shift up
            if (i_prev_lt) begin
                n_key = i_bc_key;
                n_pay = i_bc_pay;
            end else begin
                n_key = i_prev_key;
                n_pay = i_prev_pay;
            end
        end else if (i_ctl.del && !r_lt) begin
            n_key = i_next_key;
            n_pay = i_next_pay;
        end else if (i_ctl.rep && r_eq) begin
            n_pay = i_bc_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_pay <= n_pay;
        if (i_ctl.cap) begin
            r_lt <= i_valid && (r_key < i_cmp_key);
            r_eq <= i_valid && (r_key == i_cmp_key);
        end
    end

    assign o_key = r_key;
    assign o_pay = r_pay;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;
endmodule

`default_nettype wire

[tb/sv/sorted_key_table_chk.sv]
`timescale 1ns / 1ps

// watches both streams, keeps a shadow of the sorted table and checks every result beat
module sorted_key_table_chk #(
    parameter int DEPTH     = 64,
    parameter int KEY_BITS  = 32,
    parameter int DATA_BITS = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_ready,
    input  skt_pkg::t_in_beat   i_in_beat,
    input  wire                 i_out_valid,
    input  wire                 i_out_ready,
    input  skt_pkg::t_out_beat  i_out_beat,
    output int                  o_fail_count,
    output int                  o_pending
);
    import skt_pkg::*;

    localparam logic [31:0] KEY_MASK  = (KEY_BITS >= 32) ? 32'hFFFF_FFFF :
                                        ((32'd1 << KEY_BITS) - 32'd1);
    localparam logic [31:0] DATA_MASK = (DATA_BITS >= 32) ? 32'hFFFF_FFFF :
                                        ((32'd1 << DATA_BITS) - 32'd1);

    // shadow of the table, ascending keys in slots below held
    logic [31:0] shadow_key [DEPTH];
    logic [31:0] shadow_pay [DEPTH];
    int unsigned held;

    t_out_beat   due_results [$];
    t_out_beat   oldest;
    int          miscompares;

    function automatic t_out_beat table_apply(input t_in_beat b);
        t_out_beat   r;
        logic [31:0] k;
        logic [31:0] p;
        int unsigned at;
        int unsigned i;
        bit          hit;
        r = '0;
        r.status = ST_OK;
        k = b.key & KEY_MASK;
        p = b.payload & DATA_MASK;
        // first slot whose key is not below k
        at = 0;
        while (at < held && shadow_key[at] < k)
            at++;
        hit = (at < held) && (shadow_key[at] == k);
        case (b.cmd)
            CMD_CLEAR: begin
                held = 0;
            end
            CMD_INSERT: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (hit) begin
                    r.status = ST_DUP;
                end else begin
                    for (i = held; i > at; i--) begin
                        shadow_key[i] = shadow_key[i - 1];
                        shadow_pay[i] = shadow_pay[i - 1];
                    end
                    shadow_key[at] = k;
                    shadow_pay[at] = p;
                    held++;
                end
            end
            CMD_DELETE: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else if (!hit) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (i = at; i + 1 < held; i++) begin
                        shadow_key[i] = shadow_key[i + 1];
                        shadow_pay[i] = shadow_pay[i + 1];
                    end
                    held--;
                end
            end
            CMD_LOOKUP: begin
                if (hit) begin
                    r.key_out     = shadow_key[at];
                    r.payload_out = shadow_pay[at];
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            CMD_REPLACE: begin
                if (hit)
                    shadow_pay[at] = p;
                else
                    r.status = ST_NOT_FOUND;
            end
            CMD_READ: begin
                if (b.position < held && b.position < DEPTH) begin
                    r.key_out     = shadow_key[b.position];
                    r.payload_out = shadow_pay[b.position];
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: begin
                r.status = ST_RANGE;
            end
        endcase
        r.count = 7'(held);
        return r;
    endfunction

    initial begin
        held        = 0;
        miscompares = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held = 0;
            due_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                due_results.push_back(table_apply(i_in_beat));
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $error("result beat with no command outstanding");
                    miscompares++;
                end else begin
                    oldest = due_results.pop_front();
                    if (i_out_beat.status !== oldest.status) begin
                        $error("status: expected %0d, got %0d",
                               oldest.status, i_out_beat.status);
                        miscompares++;
                    end
                    if (i_out_beat.key_out !== oldest.key_out) begin
                        $error("key_out: expected %h, got %h",
                               oldest.key_out, i_out_beat.key_out);
                        miscompares++;
                    end
                    if (i_out_beat.payload_out !== oldest.payload_out) begin
                        $error("payload_out: expected %h, got %h",
                               oldest.payload_out, i_out_beat.payload_out);
                        miscompares++;
                    end
                    if (i_out_beat.count !== oldest.count) begin
                        $error("count: expected %0d, got %0d",
                               oldest.count, i_out_beat.count);
                        miscompares++;
                    end
                end
            end
        end
        o_fail_count = miscompares;
        o_pending    = due_results.size();
    end

endmodule

[tb/sv/sorted_key_table_tb.sv]
`timescale 1ns / 1ps

module sorted_key_table_tb;
    import skt_pkg::*;

    localparam int DEPTH       = 64;
    localparam int KEY_BITS    = 32;
    localparam int DATA_BITS   = 32;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 180;
    localparam int HOLD_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;

    skt_stream_if #(.T(t_in_beat))  in_if ();
    skt_stream_if #(.T(t_out_beat)) out_if ();

    int fail_count;
    int pending;

    // idling knobs, in percent per cycle
    int send_idle_pct;
    int stall_pct;

    // long receiver hold-off: the stimulus asks, the ready process serves
    int hold_asked;
    int hold_served;

    // keys drawn from a small pool so hits, duplicates and a full table are common
    logic [31:0] key_pool [$];

    // per-phase command mix (percent): clear, insert, delete; rest split evenly
    // over lookup, replace and read
    int clear_w [PHASES] = '{0, 1, 1, 2, 0, 1, 2, 1};
    int ins_w   [PHASES] = '{70, 60, 35, 20, 70, 40, 15, 45};
    int del_w   [PHASES] = '{5, 10, 25, 45, 5, 25, 50, 20};
    int pool_n  [PHASES] = '{100, 90, 40, 30, 120, 16, 60, 80};

    sorted_key_table #(
        .DEPTH     (DEPTH),
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    sorted_key_table_chk #(
        .DEPTH     (DEPTH),
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_if.valid),
        .i_in_ready   (in_if.ready),
        .i_in_beat    (in_if.beat),
        .i_out_valid  (out_if.valid),
        .i_out_ready  (out_if.ready),
        .i_out_beat   (out_if.beat),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin : ready_drive
        int left;
        left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_served) begin
                hold_served++;
                left = HOLD_CYCLES;
            end
            if (left > 0) begin
                left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // offer one command beat; returns at the edge that took it
    // ready is looked at on the falling edge, where it is settled
    task automatic offer(input t_in_beat b);
        bit took;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.beat  <= b;
        do begin
            @(negedge i_clk);
            took = in_if.ready;
            @(posedge i_clk);
        end while (!took);
    endtask

    task automatic offer_cmd(input logic [2:0] c, input logic [31:0] k,
                             input logic [31:0] p, input logic [5:0] pos);
        t_in_beat b;
        b.cmd      = c;
        b.key      = k;
        b.payload  = p;
        b.position = pos;
        offer(b);
    endtask

    // sender stops until every outstanding result has come back
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do
            @(negedge i_clk);
        while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic refill_pool(input int n);
        key_pool.delete();
        // extremes and the sign-bit neighbors always sit in the pool
        key_pool.push_back(32'h0000_0000);
        key_pool.push_back(32'hFFFF_FFFF);
        key_pool.push_back(32'h8000_0000);
        key_pool.push_back(32'h7FFF_FFFF);
        while (key_pool.size() < n)
            key_pool.push_back($urandom());
    endtask

    function automatic t_in_beat random_item(input int ph);
        t_in_beat b;
        int       r;
        int       rest;
        r    = $urandom_range(0, 99);
        rest = 100 - clear_w[ph] - ins_w[ph] - del_w[ph];
        if (r < clear_w[ph])
            b.cmd = CMD_CLEAR;
        else if (r < clear_w[ph] + ins_w[ph])
            b.cmd = CMD_INSERT;
        else if (r < clear_w[ph] + ins_w[ph] + del_w[ph])
            b.cmd = CMD_DELETE;
        else if (r < 100 - (2 * rest) / 3)
            b.cmd = CMD_LOOKUP;
        else if (r < 100 - rest / 3)
            b.cmd = CMD_REPLACE;
        else
            b.cmd = CMD_READ;
        // mostly pool keys, now and then a fresh one that is almost surely absent
        if ($urandom_range(0, 99) < 5)
            b.key = $urandom();
        else
            b.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        b.payload = $urandom();
        // reads lean toward low positions, which are live more often
        if ($urandom_range(0, 1) == 0)
            b.position = 6'($urandom_range(0, 15));
        else
            b.position = 6'($urandom_range(0, 63));
        return b;
    endfunction

    initial begin : stimulus
        int ph;
        int n;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_asked    = 0;
        hold_served   = 0;
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.beat   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: delete, lookup, replace and read on the empty table first
        offer_cmd(CMD_DELETE,  32'h0000_0005, 32'h0, 6'd0);     // empty
        offer_cmd(CMD_LOOKUP,  32'h0000_0005, 32'h0, 6'd0);     // not found
        offer_cmd(CMD_REPLACE, 32'h0000_0005, 32'h1, 6'd0);     // not found
        offer_cmd(CMD_READ,    32'h0,         32'h0, 6'd0);     // out of range
        // extremes of key and payload, inserted out of order
        offer_cmd(CMD_INSERT,  32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
        offer_cmd(CMD_INSERT,  32'h0000_0000, 32'hFFFF_FFFF, 6'd0);
        offer_cmd(CMD_INSERT,  32'h8000_0000, 32'h1234_5678, 6'd0);
        offer_cmd(CMD_INSERT,  32'h0000_0000, 32'hAAAA_5555, 6'd0);   // duplicate
        offer_cmd(CMD_LOOKUP,  32'hFFFF_FFFF, 32'h0, 6'd0);
        offer_cmd(CMD_REPLACE, 32'h8000_0000, 32'hA5A5_5A5A, 6'd0);
        offer_cmd(CMD_READ,    32'h0, 32'h0, 6'd0);
        offer_cmd(CMD_READ,    32'h0, 32'h0, 6'd1);
        offer_cmd(CMD_READ,    32'h0, 32'h0, 6'd2);
        offer_cmd(CMD_READ,    32'h0, 32'h0, 6'd3);             // just past the count
        offer_cmd(CMD_READ,    32'h0, 32'h0, 6'd63);
        offer_cmd(CMD_DELETE,  32'h0000_0005, 32'h0, 6'd0);     // absent key
        offer_cmd(CMD_DELETE,  32'h0000_0000, 32'h0, 6'd0);     // head of table
        offer_cmd(CMD_LOOKUP,  32'h0000_0000, 32'h0, 6'd0);
        offer_cmd(CMD_READ,    32'h0, 32'h0, 6'd0);
        offer_cmd(CMD_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        offer_cmd(CMD_READ,    32'h0, 32'h0, 6'd0);             // cleared table
        offer_cmd(CMD_LOOKUP,  32'hFFFF_FFFF, 32'h0, 6'd0);

        // random phases, cycling through the idling modes
        for (ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            refill_pool(pool_n[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 64; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            // back-pressure: result side frozen while commands keep coming
            if (ph == 1 || ph == 4)
                hold_asked++;
            for (n = 0; n < PHASE_BEATS; n++)
                offer(random_item(ph));
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sorted_key_table.f]
rtl/skt_pkg.sv
rtl/skt_stream_if.sv
rtl/skt_cell.sv
rtl/sorted_key_table.sv
tb/sv/sorted_key_table_chk.sv
tb/sv/sorted_key_table_tb.sv
